@@ rtl/slefh_pkg.sv @@
// Shared types and constants of the start/length/end frame hunter.
package slefh_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 7;
  localparam int unsigned PAddrW  = 4;
  localparam int unsigned PDataW  = 32;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_START_BYTE   = 2'd0,
    REG_END_BYTE     = 2'd1,
    REG_FIXED_LENGTH = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_e;

  localparam logic [ByteW-1:0] StartByteRst = 8'h00;
  localparam logic [ByteW-1:0] EndByteRst   = 8'hFF;
  localparam logic [LenW-1:0]  FixedLenRst  = 7'd0;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [LenW-1:0]  fixed_length;
  } cfg_t;

endpackage

@@ rtl/slefh_if.sv @@
// Valid/ready channel interfaces for received bytes and payload items.
interface slefh_in_if import slefh_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slefh_out_if import slefh_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] payload_byte;
  logic             last_byte;
  logic             empty_frame;
  logic [LenW-1:0]  frame_length;

  modport source (output valid, output payload_byte, output last_byte, output empty_frame,
                  output frame_length, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, input empty_frame,
                  input frame_length, output ready);
endinterface

@@ rtl/start_length_end_frame_hunter.sv @@
// Start/length/end frame hunter: top level with byte buffer and scan sequencer.
//
// Bytes are taken one at a time and kept in a circular buffer in a single RAM
// (one write port, one read port, registered read), starting at the current
// frame hypothesis. Every memory access of a scan takes an address state and a check
// state. Each rejected hypothesis adds a rescan, and a matched frame hands out its
// payload one item at a time, read back from the buffer, each item held back until
// the output register is free. Input is held off while a scan or an emit runs;
// a finished item waits in the output register while the next byte is taken. The
// buffer needs no clearing pass.
module start_length_end_frame_hunter import slefh_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD  = 64,
  parameter int unsigned BUFFER_DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready,
  slefh_in_if.sink          rx_i,
  slefh_out_if.source       tx_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned FW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CW = (FW > 9) ? FW : 9;

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_CHK0, S_LEN, S_ENDRD, S_ENDCHK, S_EMPTY, S_EMIT_RD, S_EMIT_LD, S_DONE
  } state_e;

  cfg_t             cfg;
  state_e           state_q;
  logic [AW-1:0]    start_q;
  logic [FW-1:0]    fill_q;
  logic             pend_q;
  logic [ByteW-1:0] pbyte_q;
  logic [ByteW-1:0] len_q;
  logic [1:0]       hdr_q;
  logic [LenW-1:0]  k_q;

  logic             ovalid_q;
  logic [ByteW-1:0] opay_q;
  logic             olast_q;
  logic             oempty_q;
  logic [LenW-1:0]  olen_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ByteW-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  logic             in_acc;
  logic             out_free;
  logic             full;
  logic [CW-1:0]    endpos;
  logic [CW-1:0]    emit_off;
  logic [AW-1:0]    start_inc;
  logic             emit_last;

  function automatic logic [AW-1:0] buf_addr(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(BUFFER_DEPTH)) begin
      sum = sum - (CW+1)'(BUFFER_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  slefh_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slefh_ram #(.WIDTH(ByteW), .DEPTH(BUFFER_DEPTH)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rx_i.ready        = (state_q == S_IDLE);
  assign in_acc            = rx_i.valid && rx_i.ready;
  assign out_free          = !ovalid_q || tx_o.ready;
  assign full              = (fill_q == FW'(BUFFER_DEPTH));
  assign endpos            = CW'(hdr_q) + CW'(len_q);
  assign emit_off          = CW'(hdr_q) + CW'(k_q);
  assign start_inc         = (start_q == AW'(BUFFER_DEPTH - 1)) ? '0 : start_q + 1'b1;
  assign emit_last         = (({1'b0, k_q} + 8'd1) == len_q);

  assign tx_o.valid        = ovalid_q;
  assign tx_o.payload_byte = opay_q;
  assign tx_o.last_byte    = olast_q;
  assign tx_o.empty_frame  = oempty_q;
  assign tx_o.frame_length = olen_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = rx_i.rx_byte;
    ram_waddr = buf_addr(start_q, CW'(fill_q));
    if (state_q == S_IDLE && in_acc && !full) begin
      ram_we = 1'b1;
    end else if (state_q == S_DONE && pend_q) begin
      ram_we    = 1'b1;
      ram_wdata = pbyte_q;
    end
    case (state_q)
      S_CHK0:    ram_raddr = buf_addr(start_q, CW'(1));
      S_ENDRD:   ram_raddr = buf_addr(start_q, endpos);
      S_EMIT_RD: ram_raddr = buf_addr(start_q, emit_off);
      default:   ram_raddr = start_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      start_q  <= '0;
      fill_q   <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      pbyte_q  <= '0;
      len_q    <= '0;
      hdr_q    <= '0;
      k_q      <= '0;
      opay_q   <= '0;
      olast_q  <= 1'b0;
      oempty_q <= 1'b0;
      olen_q   <= '0;
    end else begin
      if (ovalid_q && tx_o.ready && state_q != S_EMPTY) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (full) begin
              // drop oldest, rescan, then store the held byte
              start_q <= start_inc;
              fill_q  <= fill_q - 1'b1;
              pend_q  <= 1'b1;
              pbyte_q <= rx_i.rx_byte;
            end else begin
              fill_q  <= fill_q + 1'b1;
            end
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          state_q <= (fill_q == '0) ? S_DONE : S_CHK0;
        end
        S_CHK0: begin
          if (ram_rdata != cfg.start_byte) begin
            start_q <= start_inc;
            fill_q  <= fill_q - 1'b1;
            state_q <= S_HEAD;
          end else if (cfg.fixed_length != '0) begin
            len_q   <= ByteW'(cfg.fixed_length);
            hdr_q   <= 2'd1;
            state_q <= S_ENDRD;
          end else if (fill_q < FW'(2)) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          len_q   <= ram_rdata;
          hdr_q   <= 2'd2;
          state_q <= S_ENDRD;
        end
        S_ENDRD: begin
          if (len_q > ByteW'(MAX_PAYLOAD)) begin
            start_q <= start_inc;
            fill_q  <= fill_q - 1'b1;
            state_q <= S_HEAD;
          end else if (CW'(fill_q) <= endpos) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_ENDCHK;
          end
        end
        S_ENDCHK: begin
          k_q <= '0;
          if (ram_rdata != cfg.end_byte) begin
            start_q <= start_inc;
            fill_q  <= fill_q - 1'b1;
            state_q <= S_HEAD;
          end else if (len_q == '0) begin
            state_q <= S_EMPTY;
          end else begin
            state_q <= S_EMIT_RD;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            opay_q   <= '0;
            olast_q  <= 1'b1;
            oempty_q <= 1'b1;
            olen_q   <= '0;
            start_q  <= '0;
            fill_q   <= '0;
            pend_q   <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          if (out_free) begin
            state_q <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          ovalid_q <= 1'b1;
          opay_q   <= ram_rdata;
          olast_q  <= emit_last;
          oempty_q <= 1'b0;
          olen_q   <= len_q[LenW-1:0];
          k_q      <= k_q + 1'b1;
          if (emit_last) begin
            start_q <= '0;
            fill_q  <= '0;
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_EMIT_RD;
          end
        end
        S_DONE: begin
          if (pend_q) begin
            fill_q  <= fill_q + 1'b1;
            pend_q  <= 1'b0;
            state_q <= S_HEAD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // no overwrite of an item still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT_LD |-> !ovalid_q)
    else $error("output item overwritten");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(BUFFER_DEPTH) && start_q <= AW'(BUFFER_DEPTH - 1))
    else $error("buffer pointers out of range");

  a_pend_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> fill_q < FW'(BUFFER_DEPTH))
    else $error("held byte with no room in buffer");

  a_emit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_RD || state_q == S_EMIT_LD) |->
      (len_q != '0 && len_q <= ByteW'(MAX_PAYLOAD)))
    else $error("emitting a frame with bad length");

endmodule

@@ rtl/slefh_ram.sv @@
// Generic simple dual-port RAM with registered read.
module slefh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/slefh_regs.sv @@
// APB configuration registers of the frame hunter.
module slefh_regs import slefh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= StartByteRst;
      cfg_q.end_byte     <= EndByteRst;
      cfg_q.fixed_length <= FixedLenRst;
    end else if (wr_en) begin
      case (idx)
        REG_START_BYTE:   cfg_q.start_byte   <= pwdata[ByteW-1:0];
        REG_END_BYTE:     cfg_q.end_byte     <= pwdata[ByteW-1:0];
        REG_FIXED_LENGTH: cfg_q.fixed_length <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_BYTE:   prdata = PDataW'(cfg_q.start_byte);
      REG_END_BYTE:     prdata = PDataW'(cfg_q.end_byte);
      REG_FIXED_LENGTH: prdata = PDataW'(cfg_q.fixed_length);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ test/start_length_end_frame_hunter_test.sv @@
// Self-checking testbench of the start/length/end frame hunter with its own frame predictor.
module start_length_end_frame_hunter_test;
  import slefh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned BufDepth   = 128;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             last_byte;
    logic             empty_frame;
    logic [LenW-1:0]  frame_length;
  } payload_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  slefh_in_if  rx_if ();
  slefh_out_if tx_if ();

  start_length_end_frame_hunter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx_i    (rx_if),
    .tx_o    (tx_if)
  );

  // frame predictor state
  logic [ByteW-1:0] hunt_buf [BufDepth];
  int unsigned      hunt_head;
  int unsigned      hunt_fill;
  cfg_t             hunt_cfg;
  payload_item_t    frame_expect_q [$];

  logic [ByteW-1:0] rx_todo [$];
  int unsigned      rx_gap;
  int unsigned      tx_stall;
  logic             no_idle;
  logic             sink_hold;
  int unsigned      fails;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [ByteW-1:0] buf_peek(int unsigned ofs);
    return hunt_buf[(hunt_head + ofs) % BufDepth];
  endfunction

  function automatic void drop_head();
    if (hunt_fill != 0) begin
      hunt_head = (hunt_head + 1) % BufDepth;
      hunt_fill--;
    end
  endfunction

  // rescan the buffer from the current hypothesis until it waits for more bytes or matches
  function automatic void hunt_frames();
    int unsigned len;
    int unsigned hdr;
    int unsigned endpos;
    payload_item_t item;
    while (hunt_fill != 0) begin
      if (buf_peek(0) != hunt_cfg.start_byte) begin
        drop_head();
        continue;
      end
      if (hunt_cfg.fixed_length != 0) begin
        len = hunt_cfg.fixed_length;
        hdr = 1;
      end else begin
        if (hunt_fill < 2) return;
        len = buf_peek(1);
        hdr = 2;
      end
      if (len > MaxPayload) begin
        drop_head();
        continue;
      end
      endpos = hdr + len;
      if (hunt_fill <= endpos) return;
      if (buf_peek(endpos) != hunt_cfg.end_byte) begin
        drop_head();
        continue;
      end
      if (len == 0) begin
        item = '{payload_byte: '0, last_byte: 1'b1, empty_frame: 1'b1, frame_length: '0};
        frame_expect_q.push_back(item);
      end else begin
        for (int unsigned k = 0; k < len; k++) begin
          item.payload_byte = buf_peek(hdr + k);
          item.last_byte    = (k + 1 == len);
          item.empty_frame  = 1'b0;
          item.frame_length = LenW'(len);
          frame_expect_q.push_back(item);
        end
      end
      hunt_head = 0;
      hunt_fill = 0;
      return;
    end
  endfunction

  function automatic void take_rx_byte(logic [ByteW-1:0] b);
    int unsigned n_before;
    n_before = frame_expect_q.size();
    if (hunt_fill >= BufDepth) begin
      drop_head();
      hunt_frames();
      // a match here swallows the incoming byte
      if (frame_expect_q.size() != n_before) return;
    end
    hunt_buf[(hunt_head + hunt_fill) % BufDepth] = b;
    hunt_fill++;
    hunt_frames();
  endfunction

  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 11);
  endfunction

  always @(posedge clk_i) begin : rx_driver
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
      rx_gap      <= 0;
    end else begin
      if (rx_if.valid && rx_if.ready) take_rx_byte(rx_if.rx_byte);
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_gap != 0) begin
          rx_if.valid <= 1'b0;
          rx_gap      <= rx_gap - 1;
        end else if (rx_todo.size() != 0) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= rx_todo.pop_front();
          rx_gap        <= draw_gap();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_payload_item();
    payload_item_t exp;
    if (frame_expect_q.size() == 0) begin
      $error("payload item 0x%02h with nothing expected", tx_if.payload_byte);
      fails++;
      return;
    end
    exp = frame_expect_q.pop_front();
    if (tx_if.payload_byte !== exp.payload_byte) begin
      $error("payload_byte: expected 0x%02h, got 0x%02h", exp.payload_byte, tx_if.payload_byte);
      fails++;
    end
    if (tx_if.last_byte !== exp.last_byte) begin
      $error("last_byte: expected %0b, got %0b", exp.last_byte, tx_if.last_byte);
      fails++;
    end
    if (tx_if.empty_frame !== exp.empty_frame) begin
      $error("empty_frame: expected %0b, got %0b", exp.empty_frame, tx_if.empty_frame);
      fails++;
    end
    if (tx_if.frame_length !== exp.frame_length) begin
      $error("frame_length: expected %0d, got %0d", exp.frame_length, tx_if.frame_length);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin : tx_monitor
    int unsigned stall_left;
    if (!rst_ni) begin
      tx_if.ready <= 1'b0;
      tx_stall    <= 0;
    end else begin
      stall_left = tx_stall;
      if (tx_if.valid && tx_if.ready) begin
        check_payload_item();
        stall_left = draw_gap();
      end
      if (sink_hold || stall_left != 0) begin
        tx_if.ready <= 1'b0;
        tx_stall    <= (stall_left != 0) ? stall_left - 1 : 0;
      end else begin
        tx_if.ready <= 1'b1;
        tx_stall    <= 0;
      end
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [PDataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_BYTE:   hunt_cfg.start_byte   = val[ByteW-1:0];
      REG_END_BYTE:     hunt_cfg.end_byte     = val[ByteW-1:0];
      REG_FIXED_LENGTH: hunt_cfg.fixed_length = val[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_bytes(logic [ByteW-1:0] bytes [$]);
    foreach (bytes[i]) rx_todo.push_back(bytes[i]);
  endtask

  // one frame under the current settings; a bad one gets a wrong closing byte
  function automatic int unsigned queue_frame(int unsigned len, bit good_end);
    int unsigned n;
    n = 0;
    rx_todo.push_back(hunt_cfg.start_byte);
    n++;
    if (hunt_cfg.fixed_length == 0) begin
      rx_todo.push_back(ByteW'(len));
      n++;
    end
    for (int unsigned k = 0; k < len; k++) begin
      rx_todo.push_back(ByteW'($urandom));
      n++;
    end
    rx_todo.push_back(good_end ? hunt_cfg.end_byte :
                      hunt_cfg.end_byte ^ ByteW'($urandom_range(1, 255)));
    return n + 1;
  endfunction

  task automatic queue_random(int unsigned n_items);
    int unsigned added;
    int unsigned pick;
    int unsigned len;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 9);
      if (hunt_cfg.fixed_length != 0) len = hunt_cfg.fixed_length;
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(0, MaxPayload);
      else len = $urandom_range(0, 6);
      if (pick <= 5) begin
        added += queue_frame(len, 1'b1);
      end else if (pick == 6) begin
        added += queue_frame(len, 1'b0);
      end else if (pick == 7 && hunt_cfg.fixed_length == 0) begin
        rx_todo.push_back(hunt_cfg.start_byte);
        rx_todo.push_back(ByteW'($urandom_range(MaxPayload + 1, 255)));
        added += 2;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          rx_todo.push_back(ByteW'($urandom));
          added++;
        end
      end
    end
  endtask

  // all items taken, all results back, then the block's own rescan time
  task automatic wait_idle();
    do @(posedge clk_i);
    while (rx_todo.size() != 0 || rx_if.valid || frame_expect_q.size() != 0);
    repeat (1500) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    tx_if.ready   = 1'b0;
    no_idle       = 1'b0;
    sink_hold     = 1'b0;
    fails         = 0;
    hunt_head     = 0;
    hunt_fill     = 0;
    hunt_cfg      = '{start_byte: StartByteRst, end_byte: EndByteRst, fixed_length: FixedLenRst};
    foreach (hunt_buf[i]) hunt_buf[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty frame, payload of all ones, oversize lengths, bad end, good frame
    queue_bytes('{8'h00, 8'h00, 8'hFF});
    queue_bytes('{8'h00, 8'h01, 8'hFF, 8'hFF});
    queue_bytes('{8'h00, 8'h41, 8'h00, 8'hFF});
    queue_bytes('{8'h00, 8'h02, 8'h11, 8'h22, 8'h33});
    queue_bytes('{8'h00, 8'h03, 8'h00, 8'h7F, 8'h80, 8'hFF});
    wait_idle();

    apb_write(REG_FIXED_LENGTH, 32'hFFFF_FF81);
    apb_write(REG_START_BYTE, 32'h0000_00FF);
    apb_write(REG_END_BYTE, 32'hFFFF_FF00);
    queue_bytes('{8'hFF, 8'h5A, 8'h00});
    wait_idle();

    // variable length, with the sink held off while the sender keeps pushing
    apb_write(REG_FIXED_LENGTH, 32'h0000_0000);
    apb_write(REG_START_BYTE, 32'h1234_567E);
    apb_write(REG_END_BYTE, 32'h0000_007D);
    apb_write(REG_NONE, 32'hFFFF_FFFF);
    sink_hold <= 1'b1;
    queue_random(35);
    repeat (400) @(posedge clk_i);
    sink_hold <= 1'b0;
    wait_idle();

    // longest fixed payload, no idling on either side
    no_idle <= 1'b1;
    apb_write(REG_FIXED_LENGTH, {25'($urandom), 7'd64});
    apb_write(REG_START_BYTE, 32'h0000_00FF);
    apb_write(REG_END_BYTE, 32'h0000_0000);
    queue_random(60);
    wait_idle();

    no_idle <= 1'b0;
    apb_write(REG_FIXED_LENGTH, 32'($urandom_range(1, 8)));
    apb_write(REG_START_BYTE, $urandom);
    apb_write(REG_END_BYTE, $urandom);
    queue_random(20);
    wait_idle();

    // fixed length beyond the payload limit: nothing may ever match
    apb_write(REG_FIXED_LENGTH, 32'h0000_007F);
    apb_write(REG_START_BYTE, 32'h0000_0000);
    queue_bytes('{8'h00, 8'h00, 8'hFF, 8'h00, 8'h05, 8'h01, 8'h02, 8'hFF, 8'h00, 8'hFF});
    wait_idle();

    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
